// File: sv/modular_power_msb_first_unit_defines.svh
// Assertion macro shared by the modular power block.
// Used by the files that carry concurrent checks; no other dependencies.
`ifndef MODULAR_POWER_MSB_FIRST_UNIT_DEFINES_SVH
`define MODULAR_POWER_MSB_FIRST_UNIT_DEFINES_SVH

// Check a property on the rising clock, skipped while in reset.
`define MPU_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// File: sv/mpow_pkg.sv
// Shared state type for the modular power block.
// No dependencies.
package mpow_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } mpow_state_t;

endpackage

// File: sv/mpow_modmul.sv
// Iterative modular multiplier: (a * b) mod m, one multiplier bit per cycle.
// Interleaved shift-add with compare-subtract; depends on modular_power_msb_first_unit_defines.svh.
module mpow_modmul #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  logic [W-1:0] modulus,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] product
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  mul_reg, mul_next;
    logic [W-1:0]  a_reg, a_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W+1:0]  dbl, dbl_red, add, add_red;

    always_comb
    begin
        dbl     = {1'b0, acc_reg, 1'b0};
        dbl_red = (dbl >= {2'b00, modulus}) ? dbl - {2'b00, modulus} : dbl;
        add     = dbl_red + (mul_reg[W-1] ? {2'b00, a_reg} : '0);
        add_red = (add >= {2'b00, modulus}) ? add - {2'b00, modulus} : add;
        acc_next  = acc_reg;
        mul_next  = mul_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mul_next  = op_b;
            a_next    = op_a;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = add_red[W-1:0];
            mul_next = {mul_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mul_reg <= mul_next;
        a_reg   <= a_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

    `include "modular_power_msb_first_unit_defines.svh"
    `MPU_ASSERT_CLK(a_done_ends_busy, clk, rst_n, done |-> !busy, "done while busy")
    `MPU_ASSERT_CLK(a_start_busy, clk, rst_n, start |=> busy, "start did not raise busy")
    `MPU_ASSERT_CLK(a_cnt_live, clk, rst_n, busy |-> cnt_reg != '0, "busy with zero count")
endmodule

// File: sv/modular_power_msb_first_unit.sv
// Top level of the modular power block: sequencer around one modular multiplier.
// Depends on mpow_pkg, mpow_modmul and modular_power_msb_first_unit_defines.svh.
//
// Usage: present base_value, power_value and modulus_value with in_valid;
// the item transfers when in_valid and in_ready are both high. One result
// (residue, zero_modulus) is offered with out_valid and held until out_ready.
// The base is reduced first by one multiplier pass (base * 1 mod m), then each
// of the EXP_WIDTH exponent bits costs one squaring pass and, where the bit is
// one, one multiply pass, all on the shared shift-add multiplier. A zero
// modulus or zero exponent skips the passes and goes straight to the result.
// in_ready is low from transfer until the result has been taken; a stalled
// receiver holds the result and the block. Reset returns to idle with no
// result pending.
module modular_power_msb_first_unit #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] base_value,
    input  logic [63:0] power_value,
    input  logic [31:0] modulus_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] residue,
    output logic        zero_modulus
);
    import mpow_pkg::*;

    localparam int EW = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

    mpow_state_t state_reg, state_next;
    logic [MOD_WIDTH-1:0] base_reg, base_next;
    logic [MOD_WIDTH-1:0] mod_reg, mod_next;
    logic [MOD_WIDTH-1:0] r_reg, r_next;
    logic [EXP_WIDTH-1:0] exp_reg, exp_next;
    logic [EW-1:0]        idx_reg, idx_next;
    logic                 zm_reg, zm_next;
    logic                 issued_reg, issued_next;

    logic                 mm_start, mm_busy, mm_done;
    logic [MOD_WIDTH-1:0] mm_a, mm_b, mm_p;
    logic [MOD_WIDTH-1:0] one_w;

    assign one_w = MOD_WIDTH'(1);

    mpow_modmul #(.W(MOD_WIDTH)) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (mod_reg),
        .busy    (mm_busy),
        .done    (mm_done),
        .product (mm_p)
    );

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        mod_next    = mod_reg;
        r_next      = r_reg;
        exp_next    = exp_reg;
        idx_next    = idx_reg;
        zm_next     = zm_reg;
        issued_next = issued_reg;
        mm_start    = 1'b0;
        mm_a        = r_reg;
        mm_b        = r_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    base_next   = base_value[MOD_WIDTH-1:0];
                    mod_next    = modulus_value[MOD_WIDTH-1:0];
                    exp_next    = power_value[EXP_WIDTH-1:0];
                    idx_next    = EW'(EXP_WIDTH - 1);
                    r_next      = one_w;
                    issued_next = 1'b0;
                    zm_next     = (modulus_value[MOD_WIDTH-1:0] == '0);
                    if (modulus_value[MOD_WIDTH-1:0] == '0)
                    begin
                        r_next     = '0;
                        state_next = ST_DONE;
                    end
                    else if (power_value[EXP_WIDTH-1:0] == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                mm_a = one_w;
                mm_b = base_reg;
                if (!issued_reg)
                begin
                    mm_start    = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mm_done)
                begin
                    base_next   = mm_p;
                    issued_next = 1'b0;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (!issued_reg)
                begin
                    mm_start    = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mm_done)
                begin
                    r_next      = mm_p;
                    issued_next = 1'b0;
                    if (exp_reg[idx_reg])
                        state_next = ST_MULT;
                    else if (idx_reg == '0)
                        state_next = ST_DONE;
                    else
                        idx_next = idx_reg - 1'b1;
                end
            end
            ST_MULT:
            begin
                mm_b = base_reg;
                if (!issued_reg)
                begin
                    mm_start    = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mm_done)
                begin
                    r_next      = mm_p;
                    issued_next = 1'b0;
                    if (idx_reg == '0)
                        state_next = ST_DONE;
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        mod_reg  <= mod_next;
        r_reg    <= r_next;
        exp_reg  <= exp_next;
        zm_reg   <= zm_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_DONE);
    assign residue      = 32'(r_reg);
    assign zero_modulus = zm_reg;

    `include "modular_power_msb_first_unit_defines.svh"
    `MPU_ASSERT_CLK(a_excl, clk, rst_n, !(in_ready && out_valid), "ready while result held")
    `MPU_ASSERT_CLK(a_zm_res, clk, rst_n, (out_valid && zero_modulus) |-> residue == 32'd0,
        "zero modulus with nonzero residue")
    `MPU_ASSERT_CLK(a_hold, clk, rst_n, (out_valid && !out_ready) |=> $stable(residue),
        "result changed under stall")
    `MPU_ASSERT_CLK(a_mm_idle, clk, rst_n, (in_ready || out_valid) |-> !mm_busy,
        "multiplier busy outside compute")
endmodule

// File: verif/modular_power_msb_first_unit_tb.sv
// Testbench for modular_power_msb_first_unit: directed table, then random items,
// each result checked against a square-and-multiply predictor. Needs only the RTL.
module modular_power_msb_first_unit_tb;

    typedef struct {
        logic [31:0] base;
        logic [63:0] power;
        logic [31:0] modulus;
        logic        known;
        logic [31:0] residue;
        logic        zero_mod;
    } pow_row_t;

    typedef struct {
        logic [31:0] residue;
        logic        zero_mod;
    } pow_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] base_value = '0;
    logic [63:0] power_value = '0;
    logic [31:0] modulus_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] residue;
    logic        zero_modulus;

    pow_result_t pending_powers[$];
    pow_row_t    directed_rows[$];
    int          failures = 0;
    int          cycle_count = 0;
    bit          stim_done = 1'b0;

    modular_power_msb_first_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .base_value(base_value), .power_value(power_value),
        .modulus_value(modulus_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .residue(residue), .zero_modulus(zero_modulus)
    );

    always #5 clk = ~clk;

    function automatic pow_result_t mod_power(logic [31:0] b, logic [63:0] e,
                                              logic [31:0] m);
        pow_result_t res;
        logic [63:0] acc;
        logic [63:0] reduced;
        res.zero_mod = 1'b0;
        if (m == 0)
        begin
            res.residue = '0;
            res.zero_mod = 1'b1;
            return res;
        end
        if (e == 0)
        begin
            res.residue = 32'd1;
            return res;
        end
        reduced = {32'd0, b} % {32'd0, m};
        acc = 64'd1;
        for (int i = 63; i >= 0; i--)
        begin
            acc = (acc * acc) % {32'd0, m};
            if (e[i])
                acc = (acc * reduced) % {32'd0, m};
        end
        res.residue = acc[31:0];
        return res;
    endfunction

    task automatic send_power(logic [31:0] b, logic [63:0] e, logic [31:0] m);
        int gap;
        gap = $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        base_value <= b;
        power_value <= e;
        modulus_value <= m;
        pending_powers.insert(pending_powers.size(), mod_power(b, e, m));
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void add_row(logic [31:0] b, logic [63:0] e, logic [31:0] m,
                                    logic known, logic [31:0] r, logic z);
        pow_row_t t;
        t.base = b; t.power = e; t.modulus = m;
        t.known = known; t.residue = r; t.zero_mod = z;
        directed_rows.insert(directed_rows.size(), t);
    endfunction

    initial
    begin
        pow_result_t want;
        logic [31:0] m;
        add_row(32'd5, 64'd3, 32'd0, 1'b1, 32'd0, 1'b1);
        add_row(32'd5, 64'd0, 32'd0, 1'b1, 32'd0, 1'b1);
        add_row('1, '1, 32'd0, 1'b1, 32'd0, 1'b1);
        add_row(32'd7, 64'd0, 32'd1, 1'b1, 32'd1, 1'b0);
        add_row('1, 64'd0, '1, 1'b1, 32'd1, 1'b0);
        add_row(32'd7, 64'd5, 32'd1, 1'b1, 32'd0, 1'b0);
        add_row('1, '1, 32'd1, 1'b1, 32'd0, 1'b0);
        add_row(32'd0, 64'd9, 32'd13, 1'b1, 32'd0, 1'b0);
        add_row(32'd2, 64'd10, 32'd1000, 1'b1, 32'd24, 1'b0);
        add_row(32'd3, 64'd1, 32'd7, 1'b1, 32'd3, 1'b0);
        add_row('1, 64'd1, '1, 1'b1, 32'd0, 1'b0);
        add_row('1, '1, '1, 1'b0, 32'd0, 1'b0);
        add_row('1, '1, 32'hFFFF_FFFB, 1'b0, 32'd0, 1'b0);
        add_row(32'h1234_5678, 64'h8000_0000_0000_0000, '1, 1'b0, 32'd0, 1'b0);
        add_row(32'hFFFF_FFFE, 64'hAAAA_5555_F0F0_0F0F,
                32'h8000_0001, 1'b0, 32'd0, 1'b0);
        add_row(32'd2, 64'd31, 32'h8000_0000, 1'b0, 32'd0, 1'b0);
        add_row(32'h8000_0000, 64'd2, 32'd3, 1'b0, 32'd0, 1'b0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            want = mod_power(directed_rows[i].base, directed_rows[i].power,
                             directed_rows[i].modulus);
            if (directed_rows[i].known &&
                (want.residue !== directed_rows[i].residue ||
                 want.zero_mod !== directed_rows[i].zero_mod))
            begin
                $display("%0t table row %0d: expected %h/%b, predicted %h/%b", $time, i,
                         directed_rows[i].residue, directed_rows[i].zero_mod,
                         want.residue, want.zero_mod);
                failures++;
            end
            send_power(directed_rows[i].base, directed_rows[i].power,
                       directed_rows[i].modulus);
        end
        in_valid <= 1'b0;

        // hold until every result has drained
        while (pending_powers.size() != 0) @(posedge clk);

        for (int n = 0; n < 115; n++)
        begin
            case ($urandom_range(0, 9))
                0: m = 32'd0;
                1: m = 32'd1;
                2: m = $urandom_range(2, 50);
                default: m = $urandom;
            endcase
            send_power($urandom, ($urandom_range(0, 9) == 0) ? 64'd0 : rand64(), m);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(posedge clk)
    begin
        pow_result_t want;
        if (out_valid && out_ready)
        begin
            if (pending_powers.size() == 0)
            begin
                $display("%0t unexpected result: actual %h/%b", $time, residue, zero_modulus);
                failures++;
            end
            else
            begin
                want = pending_powers.pop_front();
                if (residue !== want.residue)
                begin
                    $display("%0t residue: expected %h, actual %h", $time,
                             want.residue, residue);
                    failures++;
                end
                if (zero_modulus !== want.zero_mod)
                begin
                    $display("%0t zero_modulus: expected %b, actual %b", $time,
                             want.zero_mod, zero_modulus);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000)
        begin
            $display("modular_power_msb_first_unit_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending_powers.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (failures == 0 && pending_powers.size() == 0)
            $display("modular_power_msb_first_unit_tb OK");
        else
            $display("modular_power_msb_first_unit_tb NOT OK");
        $finish;
    end

endmodule

// File: modular_power_msb_first_unit.f
+incdir+sv
sv/mpow_pkg.sv
sv/mpow_modmul.sv
sv/modular_power_msb_first_unit.sv
verif/modular_power_msb_first_unit_tb.sv
